>>> rtl/ftc_pkg.sv
// Package for the frustum culling test: sizes, codes and shared types.
package ftc_pkg;

	// Plane store geometry
	localparam int NUM_PLANES = 6;
	localparam int COEFS_PER_PLANE = 4;
	localparam int COEF_W = 32;
	localparam int ROW_W = COEFS_PER_PLANE * COEF_W;
	localparam int PLANE_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
	localparam int COEF_SEL_W = 2;

	// Arithmetic widths: Q2.30 coefficients, exact distance in 66 bits
	localparam int FRAC_BITS = 30;
	localparam int PROD_W = 2 * COEF_W;
	localparam int BIAS_W = COEF_W + 1;
	localparam int ACC_W = PROD_W + 2;

	// Request function codes
	typedef enum logic [2:0] {
		FUNC_LOAD   = 3'd0,
		FUNC_POINT  = 3'd1,
		FUNC_CIRCLE = 3'd2,
		FUNC_SPHERE = 3'd3,
		FUNC_SQUARE = 3'd4,
		FUNC_CUBOID = 3'd5
	} func_t;

	// One plane as stored in a memory row, coefficient a in the low lane
	typedef struct packed {
		logic signed [COEF_W-1:0] d;
		logic signed [COEF_W-1:0] c;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] a;
	} plane_row_t;

	// Corner bounds and radius bias of the object under test
	typedef struct packed {
		logic signed [COEF_W-1:0] x_lo;
		logic signed [COEF_W-1:0] x_hi;
		logic signed [COEF_W-1:0] y_lo;
		logic signed [COEF_W-1:0] y_hi;
		logic signed [COEF_W-1:0] z_lo;
		logic signed [COEF_W-1:0] z_hi;
		logic signed [COEF_W-1:0] bias;
	} geom_t;

	// Token that travels with each plane through the evaluation pipeline
	typedef struct packed {
		logic valid;
		logic last;
	} eval_ctl_t;

endpackage

>>> rtl/ftc_in_if.sv
// Request channel of the frustum culling test: valid, ready and request fields.
interface ftc_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [2:0]  plane_select;
	logic [1:0]  coef_select;
	logic signed [31:0] coef_value;
	logic signed [31:0] x_low;
	logic signed [31:0] y_low;
	logic signed [31:0] z_low;
	logic signed [31:0] x_high;
	logic signed [31:0] y_high;
	logic signed [31:0] z_high;
	logic signed [31:0] radius;

	modport source (
		output valid, func, plane_select, coef_select, coef_value,
		output x_low, y_low, z_low, x_high, y_high, z_high, radius,
		input  ready
	);
	modport sink (
		input  valid, func, plane_select, coef_select, coef_value,
		input  x_low, y_low, z_low, x_high, y_high, z_high, radius,
		output ready
	);
endinterface

>>> rtl/ftc_out_if.sv
// Result channel of the frustum culling test: valid, ready and visibility bit.
interface ftc_out_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface

>>> rtl/ftc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ftc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_W-1:0]    waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [ADDR_W-1:0]    raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/ftc_plane_eval.sv
// Plane evaluation pipeline: products, partial sums and corner sign test.
module ftc_plane_eval
	import ftc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  eval_ctl_t  ctl_s1,
	input  plane_row_t row_s1,
	input  geom_t      geom,
	output eval_ctl_t  ctl_s4,
	output logic       hit_s4
);
	logic signed [PROD_W-1:0] ax_s2 [2];
	logic signed [PROD_W-1:0] by_s2 [2];
	logic signed [PROD_W-1:0] cz_s2 [2];
	logic signed [BIAS_W-1:0] dsum_s2;
	logic signed [ACC_W-1:0]  xy_s3 [4];
	logic signed [ACC_W-1:0]  zd_s3 [2];
	logic signed [ACC_W-1:0]  corner_sum [8];
	logic                     any_hit;
	eval_ctl_t                ctl_s2;
	eval_ctl_t                ctl_s3;

	// Advance the control token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// Stage 2: one product per coefficient and bound, plus offset with radius
	always_ff @(posedge clk) begin
		ax_s2[0] <= PROD_W'($signed(row_s1.a)) * PROD_W'($signed(geom.x_lo));
		ax_s2[1] <= PROD_W'($signed(row_s1.a)) * PROD_W'($signed(geom.x_hi));
		by_s2[0] <= PROD_W'($signed(row_s1.b)) * PROD_W'($signed(geom.y_lo));
		by_s2[1] <= PROD_W'($signed(row_s1.b)) * PROD_W'($signed(geom.y_hi));
		cz_s2[0] <= PROD_W'($signed(row_s1.c)) * PROD_W'($signed(geom.z_lo));
		cz_s2[1] <= PROD_W'($signed(row_s1.c)) * PROD_W'($signed(geom.z_hi));
		dsum_s2  <= BIAS_W'($signed(row_s1.d)) + BIAS_W'($signed(geom.bias));
	end

	// Stage 3: xy sums for four corners, z plus scaled offset for two depths
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			xy_s3[k] <= ACC_W'(ax_s2[k % 2]) + ACC_W'(by_s2[k / 2]);
		end
		for (int j = 0; j < 2; j++) begin
			zd_s3[j] <= ACC_W'(cz_s2[j]) + (ACC_W'(dsum_s2) <<< FRAC_BITS);
		end
	end

	// Stage 4: hit when any corner lies strictly on the positive side
	always_comb begin
		any_hit = 1'b0;
		for (int k = 0; k < 8; k++) begin
			corner_sum[k] = xy_s3[k % 4] + zd_s3[k / 4];
			any_hit = any_hit | (!corner_sum[k][ACC_W-1] && (corner_sum[k] != '0));
		end
	end

	always_ff @(posedge clk) begin
		hit_s4 <= any_hit;
	end
endmodule

>>> rtl/frustum_culling_test.sv
// Top level of the frustum culling test: plane store, sequencer and result register.
// A load passes through accept, row read and write back, and gives no result.
// A test reads one plane per cycle from the plane memory, so it issues NUM_PLANES
// reads; its result goes through the evaluation pipeline to the output register.
// The block takes no new item until the current one is done, but the next item is
// taken while a result waits in the output register. Reset: per-row valid bits clear
// at once, so the store reads as zero with no sweep.
module frustum_culling_test
	import ftc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ftc_in_if.sink     items,
	ftc_out_if.source  results
);
	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_LOAD_RD = 5'b00010,
		ST_LOAD_WR = 5'b00100,
		ST_ISSUE   = 5'b01000,
		ST_DRAIN   = 5'b10000
	} state_t;

	state_t                  state_q;
	logic [NUM_PLANES-1:0]   row_valid_q;
	logic [PLANE_W-1:0]      plane_cnt_q;
	logic [PLANE_W-1:0]      ld_plane_q;
	logic [COEF_SEL_W-1:0]   ld_coef_q;
	logic [COEF_W-1:0]       ld_value_q;
	geom_t                   geom_q;
	geom_t                   geom_next;
	logic                    vis_q;
	logic                    done_q;
	logic                    out_valid_q;
	logic                    out_vis_q;
	logic                    accept;
	logic                    plane_ok;
	logic                    issue_last;
	logic                    out_free;
	logic                    emit;
	logic [PLANE_W-1:0]      raddr;
	logic [ROW_W-1:0]        rdata;
	logic [ROW_W-1:0]        old_row;
	logic [ROW_W-1:0]        new_row;
	logic                    we;
	eval_ctl_t               ctl_s1;
	logic [PLANE_W-1:0]      plane_s1;
	plane_row_t              row_s1;
	eval_ctl_t               ctl_s4;
	logic                    hit_s4;

	assign items.ready    = (state_q == ST_IDLE);
	assign accept         = items.valid && items.ready;
	assign plane_ok       = {1'b0, items.plane_select} < 4'(NUM_PLANES);
	assign issue_last     = (plane_cnt_q == PLANE_W'(NUM_PLANES - 1));
	assign out_free       = !out_valid_q || results.ready;
	assign emit           = (state_q == ST_DRAIN) && done_q && out_free;
	assign results.valid  = out_valid_q;
	assign results.visible = out_vis_q;

	// Fold the object into corners so every test is an any-corner test
	always_comb begin
		geom_next.x_lo = items.x_low;
		geom_next.x_hi = items.x_high;
		geom_next.y_lo = items.y_low;
		geom_next.y_hi = items.y_high;
		geom_next.z_lo = items.z_low;
		geom_next.z_hi = items.z_high;
		geom_next.bias = '0;
		unique case (func_t'(items.func))
			FUNC_POINT, FUNC_SPHERE: begin
				geom_next.x_hi = items.x_low;
				geom_next.y_hi = items.y_low;
				geom_next.z_hi = items.z_low;
				if (func_t'(items.func) == FUNC_SPHERE) begin
					geom_next.bias = items.radius;
				end
			end
			FUNC_CIRCLE: begin
				geom_next.x_hi = items.x_low;
				geom_next.y_hi = items.y_low;
				geom_next.z_lo = '0;
				geom_next.z_hi = '0;
				geom_next.bias = items.radius;
			end
			FUNC_SQUARE: begin
				geom_next.z_lo = '0;
				geom_next.z_hi = '0;
			end
			default: ;
		endcase
	end

	// Plane memory: one row per plane, read-modify-write for loads
	assign raddr = (state_q == ST_ISSUE) ? plane_cnt_q : ld_plane_q;
	assign we    = (state_q == ST_LOAD_WR);

	ftc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_PLANES)
	) u_plane_ram (
		.clk   (clk),
		.we    (we),
		.waddr (ld_plane_q),
		.wdata (new_row),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Merge the new coefficient; a row never written counts as zero
	always_comb begin
		old_row = row_valid_q[ld_plane_q] ? rdata : '0;
		new_row = old_row;
		for (int k = 0; k < COEFS_PER_PLANE; k++) begin
			if (ld_coef_q == COEF_SEL_W'(k)) begin
				new_row[k*COEF_W +: COEF_W] = ld_value_q;
			end
		end
	end

	// Mask unwritten rows on the test read path
	assign row_s1 = row_valid_q[plane_s1] ? plane_row_t'(rdata) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= (state_q == ST_ISSUE);
			ctl_s1.last  <= (state_q == ST_ISSUE) && issue_last;
		end
	end

	always_ff @(posedge clk) begin
		plane_s1 <= plane_cnt_q;
	end

	ftc_plane_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.row_s1 (row_s1),
		.geom   (geom_q),
		.ctl_s4 (ctl_s4),
		.hit_s4 (hit_s4)
	);

	// Hold the request payload for the duration of the operation
	always_ff @(posedge clk) begin
		if (accept) begin
			ld_plane_q <= items.plane_select[PLANE_W-1:0];
			ld_coef_q  <= items.coef_select;
			ld_value_q <= items.coef_value;
			geom_q     <= geom_next;
		end
	end

	// Sequence loads and tests, fold plane hits, deliver the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_valid_q <= '0;
			plane_cnt_q <= '0;
			vis_q       <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_vis_q   <= 1'b0;
		end else begin
			// Load the output register, or release it once taken
			if (emit) begin
				out_valid_q <= 1'b1;
				out_vis_q   <= vis_q;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctl_s4.valid) begin
				vis_q <= vis_q & hit_s4;
				if (ctl_s4.last) begin
					done_q <= 1'b1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (func_t'(items.func))
							FUNC_LOAD: begin
								if (plane_ok) begin
									state_q <= ST_LOAD_RD;
								end
							end
							FUNC_POINT, FUNC_CIRCLE, FUNC_SPHERE,
							FUNC_SQUARE, FUNC_CUBOID: begin
								plane_cnt_q <= '0;
								vis_q       <= 1'b1;
								done_q      <= 1'b0;
								state_q     <= ST_ISSUE;
							end
							default: ;
						endcase
					end
				end
				ST_LOAD_RD: begin
					state_q <= ST_LOAD_WR;
				end
				ST_LOAD_WR: begin
					row_valid_q[ld_plane_q] <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_ISSUE: begin
					plane_cnt_q <= plane_cnt_q + 1'b1;
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (emit) begin
						done_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> bench/frustum_culling_test_tb.sv
// Self-checking bench for the frustum culling test block: plane loads and visibility tests.
`timescale 1ns / 1ps

module frustum_culling_test_tb;
	import ftc_pkg::*;

	localparam int  ITEM_COUNT = 1750;
	localparam int  CYCLE_LIMIT = 600000;
	localparam int  DRAIN_CYCLES = 2 * (NUM_PLANES + 5) + 8;
	localparam int  SHOWN_MISMATCHES = 10;

	// Coefficient lanes of one plane
	localparam int COEF_A = 0;
	localparam int COEF_B = 1;
	localparam int COEF_C = 2;
	localparam int COEF_D = 3;

	// Function codes the block must ignore
	localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
	localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] Q_ONE = 32'sh4000_0000;

	typedef struct {
		logic [2:0]         func;
		logic [2:0]         plane;
		logic [1:0]         coef;
		logic signed [31:0] value;
		logic signed [31:0] x_lo;
		logic signed [31:0] y_lo;
		logic signed [31:0] z_lo;
		logic signed [31:0] x_hi;
		logic signed [31:0] y_hi;
		logic signed [31:0] z_hi;
		logic signed [31:0] rad;
	} cull_req_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_QUARTER, RX_TRICKLE} rx_mode_t;

	logic clk;
	logic arst_n;

	ftc_in_if  items_if ();
	ftc_out_if results_if ();

	frustum_culling_test i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if)
	);

	// Bench copy of the plane store and the visibility bits still owed
	logic signed [31:0] plane_store [NUM_PLANES][COEFS_PER_PLANE];
	bit                 visible_due [$];
	cull_req_t          cull_requests [$];
	cull_req_t          cur_req;

	bit       req_taken;
	bit       want_visible;
	int       n_accepted;
	int       n_counted;
	int       mismatches;
	int       cycle_count;
	int       burst_left = 8;
	int       gap_left;
	int       rx_left;
	int       rx_tick;
	rx_mode_t rx_mode = RX_OPEN;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic signed [69:0] to_wide(input logic signed [31:0] v);
		return v;
	endfunction

	// True if the scaled distance to plane p, plus bias, is strictly positive
	function automatic bit plane_clears(input int p, input logic signed [31:0] x, y, z,
		input bit use_z, input logic signed [31:0] bias);
		logic signed [69:0] reach;
		reach = to_wide(plane_store[p][COEF_A]) * to_wide(x)
			+ to_wide(plane_store[p][COEF_B]) * to_wide(y)
			+ (to_wide(plane_store[p][COEF_D]) <<< FRAC_BITS)
			+ (to_wide(bias) <<< FRAC_BITS);
		if (use_z) begin
			reach = reach + to_wide(plane_store[p][COEF_C]) * to_wide(z);
		end
		return reach > 0;
	endfunction

	// Visibility of a test request against every plane in the store
	function automatic bit predict_visible(input cull_req_t r);
		bit vis;
		bit hit;
		vis = 1'b1;
		for (int p = 0; p < NUM_PLANES; p++) begin
			hit = 1'b0;
			case (r.func)
				FUNC_POINT: begin
					hit = plane_clears(p, r.x_lo, r.y_lo, r.z_lo, 1'b1, 0);
				end
				FUNC_CIRCLE: begin
					hit = plane_clears(p, r.x_lo, r.y_lo, 0, 1'b0, r.rad);
				end
				FUNC_SPHERE: begin
					hit = plane_clears(p, r.x_lo, r.y_lo, r.z_lo, 1'b1, r.rad);
				end
				FUNC_SQUARE: begin
					for (int k = 0; k < 4; k++)
						hit |= plane_clears(p, (k & 1) ? r.x_hi : r.x_lo,
							(k & 2) ? r.y_hi : r.y_lo, 0, 1'b0, 0);
				end
				default: begin
					for (int k = 0; k < 8; k++)
						hit |= plane_clears(p, (k & 1) ? r.x_hi : r.x_lo,
							(k & 2) ? r.y_hi : r.y_lo, (k & 4) ? r.z_hi : r.z_lo, 1'b1, 0);
				end
			endcase
			if (!hit) vis = 1'b0;
		end
		return vis;
	endfunction

	function automatic cull_req_t noise_req();
		cull_req_t r;
		r.func = 3'($urandom);
		r.plane = 3'($urandom);
		r.coef = 2'($urandom);
		r.value = $urandom;
		r.x_lo = $urandom;
		r.y_lo = $urandom;
		r.z_lo = $urandom;
		r.x_hi = $urandom;
		r.y_hi = $urandom;
		r.z_hi = $urandom;
		r.rad = $urandom;
		return r;
	endfunction

	function automatic cull_req_t load_req(input int p, input int c, input logic signed [31:0] v);
		cull_req_t r;
		r = noise_req();
		r.func = FUNC_LOAD;
		r.plane = 3'(p);
		r.coef = 2'(c);
		r.value = v;
		return r;
	endfunction

	function automatic cull_req_t shape_req(input logic [2:0] f,
		input logic signed [31:0] xl, yl, zl, xh, yh, zh, rd);
		cull_req_t r;
		r = noise_req();
		r.func = f;
		r.x_lo = xl;
		r.y_lo = yl;
		r.z_lo = zl;
		r.x_hi = xh;
		r.y_hi = yh;
		r.z_hi = zh;
		r.rad = rd;
		return r;
	endfunction

	// Near-axis normal for a box-shaped frustum, offset between 200 and 4000 units out
	function automatic logic signed [31:0] box_coef(input int p, input int c);
		int mag;
		if (c == COEF_D) return $urandom_range(200, 4000);
		if (c == p / 2) begin
			mag = Q_ONE - int'($urandom_range(0, 1 << 22));
			return (p % 2) ? mag : -mag;
		end
		return int'($urandom_range(0, 1 << 25)) - (1 << 24);
	endfunction

	function automatic logic signed [31:0] coord(input bit wide);
		if (wide) return $urandom;
		return int'($urandom_range(0, 12000)) - 6000;
	endfunction

	function automatic logic signed [31:0] radius_of(input bit wide);
		if (wide) return $urandom;
		return int'($urandom_range(0, 3000)) - 600;
	endfunction

	task automatic push_req(input cull_req_t r);
		cull_requests.push_back(r);
		if (!(r.func > FUNC_CUBOID || (r.func == FUNC_LOAD && r.plane >= NUM_PLANES)))
			n_counted++;
	endtask

	// Stimulus, reset and end of run
	initial begin
		cull_req_t r;
		int        start;
		int        slot;
		int        n_tests;
		int        total;
		bit        wide;
		bit        w;

		arst_n = 1'b0;
		items_if.valid = 1'b0;
		items_if.func = FUNC_LOAD;
		items_if.plane_select = '0;
		items_if.coef_select = '0;
		items_if.coef_value = '0;
		items_if.x_low = '0;
		items_if.y_low = '0;
		items_if.z_low = '0;
		items_if.x_high = '0;
		items_if.y_high = '0;
		items_if.z_high = '0;
		items_if.radius = '0;
		results_if.ready = 1'b0;
		for (int p = 0; p < NUM_PLANES; p++)
			for (int c = 0; c < COEFS_PER_PLANE; c++)
				plane_store[p][c] = '0;

		// Empty store: only a positive radius can pass
		push_req(shape_req(FUNC_POINT, 0, 0, 0, 0, 0, 0, 0));
		push_req(shape_req(FUNC_CIRCLE, S32_MIN, S32_MAX, 0, 0, 0, 0, S32_MAX));
		push_req(shape_req(FUNC_SPHERE, 5, -5, 7, 0, 0, 0, S32_MIN));
		push_req(shape_req(FUNC_SQUARE, S32_MIN, S32_MIN, 0, S32_MAX, S32_MAX, 0, 0));
		push_req(shape_req(FUNC_CUBOID, S32_MIN, S32_MIN, S32_MIN,
			S32_MAX, S32_MAX, S32_MAX, S32_MAX));
		// Loads to absent planes and spare function codes
		push_req(load_req(NUM_PLANES, COEF_A, S32_MAX));
		push_req(load_req(7, COEF_D, -1));
		r = noise_req();
		r.func = FUNC_SPARE_LO;
		push_req(r);
		r = noise_req();
		r.func = FUNC_SPARE_HI;
		push_req(r);
		// Extreme coefficients on the first plane, the rest pass everything
		push_req(load_req(0, COEF_A, S32_MIN));
		push_req(load_req(0, COEF_B, S32_MAX));
		push_req(load_req(0, COEF_C, S32_MIN));
		push_req(load_req(0, COEF_D, S32_MAX));
		for (int p = 1; p < NUM_PLANES; p++)
			push_req(load_req(p, COEF_D, 1));
		push_req(shape_req(FUNC_POINT, S32_MIN, S32_MIN, S32_MIN, 0, 0, 0, 0));
		push_req(shape_req(FUNC_POINT, S32_MAX, S32_MAX, S32_MAX, 0, 0, 0, 0));
		push_req(shape_req(FUNC_SPHERE, 0, 0, 0, 0, 0, 0, S32_MIN));
		push_req(shape_req(FUNC_CIRCLE, S32_MAX, S32_MIN, 0, 0, 0, 0, -3));
		push_req(shape_req(FUNC_CUBOID, S32_MAX, S32_MAX, S32_MAX,
			S32_MIN, S32_MIN, S32_MIN, 0));
		push_req(shape_req(FUNC_SQUARE, S32_MAX, S32_MIN, 0, S32_MIN, S32_MAX, 0, 0));

		// Random phases: load a whole frustum, then test objects against it
		while (n_counted < ITEM_COUNT) begin
			wide = ($urandom_range(0, 9) < 2);
			start = $urandom_range(0, NUM_PLANES * COEFS_PER_PLANE - 1);
			for (int i = 0; i < NUM_PLANES * COEFS_PER_PLANE; i++) begin
				slot = (start + i) % (NUM_PLANES * COEFS_PER_PLANE);
				push_req(load_req(slot / COEFS_PER_PLANE, slot % COEFS_PER_PLANE,
					wide ? $urandom : box_coef(slot / COEFS_PER_PLANE,
					slot % COEFS_PER_PLANE)));
				if ($urandom_range(0, 9) == 0) push_req(noise_req());
			end
			n_tests = $urandom_range(30, 80);
			for (int i = 0; i < n_tests; i++) begin
				slot = $urandom_range(0, 99);
				w = wide || ($urandom_range(0, 9) == 0);
				if (slot < 8) begin
					start = $urandom_range(0, NUM_PLANES - 1);
					slot = $urandom_range(COEF_A, COEF_D);
					push_req(load_req(start, slot, box_coef(start, slot)));
				end else if (slot < 13) begin
					push_req(noise_req());
				end else begin
					push_req(shape_req(3'($urandom_range(FUNC_POINT, FUNC_CUBOID)),
						coord(w), coord(w), coord(w), coord(w), coord(w), coord(w),
						radius_of(w)));
				end
			end
		end
		total = cull_requests.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (n_accepted == total);
		while (visible_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("frustum_culling_test_tb OK");
		end else begin
			$display("frustum_culling_test_tb NOT OK");
		end
		$finish;
	end

	// Drive requests in bursts separated by random gaps; hold until accepted
	always @(negedge clk) begin
		if (arst_n && (!items_if.valid || req_taken)) begin
			if (gap_left != 0) begin
				gap_left--;
				items_if.valid <= 1'b0;
			end else if (cull_requests.size() != 0) begin
				cur_req = cull_requests.pop_front();
				items_if.func <= cur_req.func;
				items_if.plane_select <= cur_req.plane;
				items_if.coef_select <= cur_req.coef;
				items_if.coef_value <= cur_req.value;
				items_if.x_low <= cur_req.x_lo;
				items_if.y_low <= cur_req.y_lo;
				items_if.z_low <= cur_req.z_lo;
				items_if.x_high <= cur_req.x_hi;
				items_if.y_high <= cur_req.y_hi;
				items_if.z_high <= cur_req.z_hi;
				items_if.radius <= cur_req.rad;
				items_if.valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				items_if.valid <= 1'b0;
			end
		end
	end

	// Stall the result side in modes that are redrawn at random
	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(RX_OPEN, RX_TRICKLE));
				rx_left = $urandom_range(20, 200);
			end else begin
				rx_left--;
			end
			rx_tick++;
			case (rx_mode)
				RX_OPEN: results_if.ready <= 1'b1;
				RX_COIN: results_if.ready <= 1'($urandom_range(0, 1));
				RX_QUARTER: results_if.ready <= (rx_tick % 4 == 0);
				default: results_if.ready <= ($urandom_range(0, 15) == 0);
			endcase
		end
	end

	// Predict on each accepted request and check each accepted result
	always @(posedge clk) begin
		req_taken <= arst_n && items_if.valid && items_if.ready;
		if (arst_n && items_if.valid && items_if.ready) begin
			n_accepted <= n_accepted + 1;
			if (cur_req.func == FUNC_LOAD) begin
				if (cur_req.plane < NUM_PLANES)
					plane_store[cur_req.plane][cur_req.coef] = cur_req.value;
			end else if (cur_req.func <= FUNC_CUBOID) begin
				visible_due.push_back(predict_visible(cur_req));
			end
		end
		if (arst_n && results_if.valid && results_if.ready) begin
			if (visible_due.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("unexpected result: visible %0b", results_if.visible);
			end else begin
				want_visible = visible_due.pop_front();
				if (results_if.visible !== want_visible) begin
					mismatches++;
					if (mismatches <= SHOWN_MISMATCHES)
						$display("visible mismatch: expected %0b, got %0b",
							want_visible, results_if.visible);
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("frustum_culling_test_tb NOT OK");
			$finish;
		end
	end

endmodule
